// ===== hw/rtl/ppi8255_pkg.sv =====
`default_nettype none

package ppi8255_pkg;

  // access kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CTRL  = 2'd2;
  localparam logic [1:0] KIND_PIN   = 2'd3;

  // port addresses
  localparam logic [1:0] PORT_A    = 2'd0;
  localparam logic [1:0] PORT_B    = 2'd1;
  localparam logic [1:0] PORT_C    = 2'd2;
  localparam logic [1:0] PORT_NONE = 2'd3;

  // control byte applied at reset
  localparam logic [7:0] CTRL_RESET = 8'h9b;

  // port C lower nibble, narrowed when group A handshake owns bit 3
  localparam logic [7:0] C_LOW_FULL  = 8'h0f;
  localparam logic [7:0] C_LOW_SHORT = 8'h07;
  localparam logic [7:0] C_UPPER     = 8'hf0;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] port;
    logic [7:0] data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic [7:0] drive_c;
    logic       intr_a;
    logic       intr_b;
  } out_beat_t;

  // masks that follow from the mode byte alone
  typedef struct packed {
    logic [7:0] im_a;
    logic [7:0] im_b;
    logic [7:0] im_c;
    logic [7:0] wm_c;
    logic [7:0] srm;
    logic [7:0] hm;
  } mode_masks_t;

endpackage

`default_nettype wire

// ===== hw/rtl/parallel_port_interface_8255.sv =====
`default_nettype none

// Channel   Handshake              Beat
// ------    ---------------------  ------------------------------------------
// input     in_valid / in_stall    in_item  : kind, port, data
// result    out_valid / out_stall  out_item : read data, pin values, masks, irq
//
// One access enters the input register, passes the state update logic and
// lands in the result register; one beat per cycle is sustained while
// out_stall stays low. Reset (synchronous, rst_n low) applies control
// byte 0x9b. While a result waits under out_stall, the input register holds
// its beat and in_stall rises only when that register is also occupied.

module parallel_port_interface_8255 (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire ppi8255_pkg::in_beat_t  in_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output ppi8255_pkg::out_beat_t      out_item
);

  // Recompute the interrupt status bits from status and enables
  function automatic logic [7:0] eval_intr(input logic [7:0] c, input logic [7:0] s_in,
                                           input logic [7:0] e);
    logic [7:0] s;
    s = s_in;
    if (c[6]) begin
      s[3] = (e[6] & s[7] & s[6]) | (e[4] & s[4] & s[6]);
    end else if (c[5]) begin
      if (c[4]) begin
        s[3] = e[6] & s[5] & s[4];
      end else begin
        s[3] = e[6] & s[6] & s[7];
      end
    end
    if (c[2]) begin
      s[0] = e[2] & s[1] & s[2];
    end
    return s;
  endfunction

  // Derive direction, write, set/reset and handshake masks from a mode byte
  function automatic ppi8255_pkg::mode_masks_t mode_masks(input logic [7:0] c);
    ppi8255_pkg::mode_masks_t m;
    logic [7:0] low;
    m.im_a = {8{c[4]}};
    m.im_b = {8{c[1]}};
    m.im_c = '0;
    m.wm_c = '0;
    m.srm  = '0;
    m.hm   = '0;
    if (c[6]) begin
      m.im_c = 8'h50;
      m.hm   = 8'hf8;
    end else if (c[5]) begin
      if (c[4]) begin
        m.srm  = 8'hc0;
        m.im_c = 8'h10;
        m.hm   = 8'h38;
      end else begin
        m.srm  = 8'h30;
        m.im_c = 8'h40;
        m.hm   = 8'hc8;
      end
    end else begin
      if (c[3]) begin
        m.im_c = ppi8255_pkg::C_UPPER;
      end
      m.srm  = ppi8255_pkg::C_UPPER;
      m.wm_c = ppi8255_pkg::C_UPPER;
    end
    low = (c[6] | c[5]) ? ppi8255_pkg::C_LOW_SHORT : ppi8255_pkg::C_LOW_FULL;
    if (!c[2]) begin
      m.srm  = m.srm | low;
      m.wm_c = m.wm_c | low;
      if (c[0]) begin
        m.im_c = m.im_c | low;
      end
    end else begin
      m.im_c = m.im_c | 8'h04;
      m.hm   = m.hm | 8'h07;
    end
    return m;
  endfunction

  logic                    in_vld_r;
  ppi8255_pkg::in_beat_t   in_item_r;
  logic                    out_vld_r;
  ppi8255_pkg::out_beat_t  out_item_r;
  logic                    adv;

  logic [7:0] mode_r, mode_nxt;
  logic [7:0] ol_r [3];
  logic [7:0] ol_nxt [3];
  logic [7:0] sl_r [2];
  logic [7:0] sl_nxt [2];
  logic [7:0] pin_r [3];
  logic [7:0] pin_nxt [3];
  logic [7:0] hs_r, hs_nxt;
  logic [7:0] ie_r, ie_nxt;

  logic [7:0]                rd;
  logic [7:0]                hs_tmp;
  logic [7:0]                bit_sel;
  logic [7:0]                plain;
  logic                      again;
  ppi8255_pkg::mode_masks_t  mk;
  ppi8255_pkg::mode_masks_t  mk_nxt;
  ppi8255_pkg::out_beat_t    res;

  // Advance when the result register is free or being emptied
  assign adv      = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~adv;

  // Apply one access to the state
  always_comb begin
    mode_nxt = mode_r;
    ol_nxt   = ol_r;
    sl_nxt   = sl_r;
    pin_nxt  = pin_r;
    hs_nxt   = hs_r;
    ie_nxt   = ie_r;
    rd       = '0;
    hs_tmp   = hs_r;
    again    = 1'b0;
    plain    = '0;
    mk       = mode_masks(mode_r);
    bit_sel  = 8'b1 << in_item_r.data[3:1];
    unique case (in_item_r.kind)
      ppi8255_pkg::KIND_CTRL: begin
        if (in_item_r.data[7]) begin
          // mode set: clear latches and enables, set status bits 7 and 1 for handshake groups
          mode_nxt  = in_item_r.data;
          ol_nxt[0] = '0;
          ol_nxt[1] = '0;
          ol_nxt[2] = '0;
          sl_nxt[0] = '0;
          sl_nxt[1] = '0;
          ie_nxt    = '0;
          hs_tmp    = {in_item_r.data[6] | in_item_r.data[5], 5'b0, in_item_r.data[2], 1'b0};
          hs_nxt    = eval_intr(in_item_r.data, hs_tmp, 8'h00);
        end else begin
          // bit set/reset: enables always, port C latch only where allowed
          if (in_item_r.data[0]) begin
            ie_nxt    = ie_r | bit_sel;
            ol_nxt[2] = ol_r[2] | (bit_sel & mk.srm);
          end else begin
            ie_nxt    = ie_r & ~bit_sel;
            ol_nxt[2] = ol_r[2] & ~(bit_sel & mk.srm);
          end
          hs_nxt = eval_intr(mode_r, hs_r, ie_nxt);
        end
      end
      ppi8255_pkg::KIND_READ: begin
        if (in_item_r.port != ppi8255_pkg::PORT_NONE) begin
          pin_nxt[in_item_r.port] = in_item_r.data;
        end
        case (in_item_r.port)
          ppi8255_pkg::PORT_A: begin
            if (mode_r[6] | mode_r[5]) begin
              if (hs_r[5]) begin
                hs_tmp[4] = 1'b1;
                hs_tmp[5] = 1'b0;
                hs_nxt    = eval_intr(mode_r, hs_tmp, ie_r);
              end
              rd = sl_r[0];
            end else begin
              rd = (in_item_r.data & mk.im_a) | (ol_r[0] & ~mk.im_a);
            end
          end
          ppi8255_pkg::PORT_B: begin
            if (mode_r[2]) begin
              if (hs_r[1]) begin
                hs_tmp[2] = 1'b1;
                hs_tmp[1] = 1'b0;
                hs_nxt    = eval_intr(mode_r, hs_tmp, ie_r);
              end
              rd = sl_r[1];
            end else begin
              rd = (in_item_r.data & mk.im_b) | (ol_r[1] & ~mk.im_b);
            end
          end
          ppi8255_pkg::PORT_C: begin
            plain = (in_item_r.data & mk.im_c) | (ol_r[2] & ~mk.im_c);
            rd    = (hs_r & mk.hm) | (plain & ~mk.hm);
          end
          default: rd = '0;
        endcase
      end
      ppi8255_pkg::KIND_WRITE: begin
        case (in_item_r.port)
          ppi8255_pkg::PORT_A: begin
            if (mode_r[6] | (mode_r[5] & ~mode_r[4])) begin
              sl_nxt[0] = in_item_r.data;
              hs_tmp[7] = 1'b0;
              hs_nxt    = eval_intr(mode_r, hs_tmp, ie_r);
            end else begin
              ol_nxt[0] = in_item_r.data;
            end
          end
          ppi8255_pkg::PORT_B: begin
            if (mode_r[2] & ~mode_r[1]) begin
              sl_nxt[1] = in_item_r.data;
              hs_tmp[1] = 1'b0;
              hs_nxt    = eval_intr(mode_r, hs_tmp, ie_r);
            end else begin
              ol_nxt[1] = in_item_r.data;
            end
          end
          ppi8255_pkg::PORT_C: begin
            ol_nxt[2] = (in_item_r.data & mk.wm_c) | (ol_r[2] & ~mk.wm_c);
          end
          default: ol_nxt = ol_r;
        endcase
      end
      ppi8255_pkg::KIND_PIN: begin
        if (in_item_r.port != ppi8255_pkg::PORT_NONE) begin
          pin_nxt[in_item_r.port] = in_item_r.data;
        end
        // strobes arrive on port C pins
        if (in_item_r.port == ppi8255_pkg::PORT_C) begin
          if (mode_r[6]) begin
            if (in_item_r.data[4]) begin
              sl_nxt[0] = pin_r[0];
              hs_tmp[5] = 1'b1;
              again     = 1'b1;
            end
          end else begin
            if (mode_r[5] & in_item_r.data[4]) begin
              sl_nxt[0] = pin_r[0];
              hs_tmp[5] = 1'b1;
              again     = 1'b1;
            end
            if (mode_r[2] & in_item_r.data[2]) begin
              sl_nxt[1] = pin_r[1];
              hs_tmp[1] = 1'b1;
              again     = 1'b1;
            end
          end
          if (again) begin
            hs_nxt = eval_intr(mode_r, hs_tmp, ie_r);
          end
        end
      end
      default: rd = '0;
    endcase

    // form the result from the updated state
    mk_nxt        = mode_masks(mode_nxt);
    res.read_data = rd;
    res.out_a     = ol_nxt[0] | mk_nxt.im_a;
    res.out_b     = ol_nxt[1] | mk_nxt.im_b;
    res.out_c     = ol_nxt[2] | mk_nxt.im_c;
    res.drive_a   = ~mk_nxt.im_a;
    res.drive_b   = ~mk_nxt.im_b;
    res.drive_c   = ~mk_nxt.im_c;
    res.intr_a    = hs_nxt[3];
    res.intr_b    = hs_nxt[0];
  end

  // Hold or load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // Advance the state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      mode_r    <= ppi8255_pkg::CTRL_RESET;
      ol_r[0]   <= '0;
      ol_r[1]   <= '0;
      ol_r[2]   <= '0;
      sl_r[0]   <= '0;
      sl_r[1]   <= '0;
      pin_r[0]  <= '0;
      pin_r[1]  <= '0;
      pin_r[2]  <= '0;
      hs_r      <= '0;
      ie_r      <= '0;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
        mode_r    <= mode_nxt;
        ol_r      <= ol_nxt;
        sl_r      <= sl_nxt;
        pin_r     <= pin_nxt;
        hs_r      <= hs_nxt;
        ie_r      <= ie_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
